[rtl/ufe_pkg.sv]
// ----------------------------------------------------------------------------
// ufe_pkg
// Shared types, constants and helpers for the disjoint-set engine.
// ----------------------------------------------------------------------------
package ufe_pkg;

  // Default table depth
  localparam int unsigned NODES_DEF = 1024;

  // Fixed field widths of the channels
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned NODE_FW = 10;
  localparam int unsigned SIZE_FW = 11;

  // Reset value of the node count register
  localparam logic [SIZE_FW-1:0] NUM_NODES_RST = 11'd1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_UNION = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_COUNT = 2'd3
  } action_t;

  // One request as taken from the input channel
  typedef struct packed {
    action_t              action;
    logic [NODE_FW-1:0]   node_a;
    logic [NODE_FW-1:0]   node_b;
  } cmd_t;

  // One answer as handed to the output register
  typedef struct packed {
    logic [NODE_FW-1:0]   root_node;
    logic [SIZE_FW-1:0]   set_size;
    logic                 same_set;
    logic                 merged;
    logic [SIZE_FW-1:0]   set_count;
  } result_t;

  // Effective node count: zero acts as one, the table depth is the ceiling
  function automatic logic [SIZE_FW-1:0] clamp_nodes(input logic [SIZE_FW-1:0] v,
                                                     input int unsigned nodes);
    logic [SIZE_FW-1:0] r;
    if (v == '0) begin
      r = 11'd1;
    end else if (32'(v) > nodes) begin
      r = SIZE_FW'(nodes);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/ufe_table.sv]
// ----------------------------------------------------------------------------
// ufe_table
// Node table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ufe_table
  import ufe_pkg::*;
#(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned NODE_W = $clog2(NODES),
  parameter int unsigned E_W    = NODE_W + 2
) (
  input  logic              clk,
  input  logic              we,
  input  logic [NODE_W-1:0] waddr,
  input  logic [E_W-1:0]    wdata,
  input  logic [NODE_W-1:0] raddr,
  output logic [E_W-1:0]    rdata
);

  logic [E_W-1:0] mem_r [NODES];
  logic [E_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port (old data on a same-address write)
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ufe_seq.sv]
// ----------------------------------------------------------------------------
// ufe_seq
// Action sequencer: clearing sweep, two-pass find with path compression,
// union by size and the running set count.
// ----------------------------------------------------------------------------
module ufe_seq
  import ufe_pkg::*;
#(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned NODE_W = $clog2(NODES),
  parameter int unsigned SZ_W   = NODE_W + 1,
  parameter int unsigned E_W    = SZ_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [SIZE_FW-1:0] n_new,
  input  logic [SIZE_FW-1:0] n_used,
  // request side
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  // answer side
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  // table port
  output logic               mem_we,
  output logic [NODE_W-1:0]  mem_waddr,
  output logic [E_W-1:0]     mem_wdata,
  output logic [NODE_W-1:0]  mem_raddr,
  input  logic [E_W-1:0]     mem_rdata
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_F1    = 7'b0000100,
    S_F2    = 7'b0001000,
    S_NEXT  = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [E_W-1:0] ENTRY_SINGLE = {1'b1, SZ_W'(1)};
  localparam logic [NODE_W-1:0] LAST_IDX  = NODE_W'(NODES - 1);

  state_t              state_r,     state_nxt;
  logic [NODE_W-1:0]   clr_addr_r,  clr_addr_nxt;
  logic [SIZE_FW-1:0]  sets_left_r, sets_left_nxt;
  logic                which_r,     which_nxt;
  action_t             act_r,       act_nxt;
  logic [NODE_W-1:0]   b_r,         b_nxt;
  logic [NODE_W-1:0]   cur_r,       cur_nxt;
  logic [NODE_W-1:0]   start_r,     start_nxt;
  logic [NODE_W-1:0]   root_r,      root_nxt;
  logic [NODE_W-1:0]   xroot_r,     xroot_nxt;
  logic [SZ_W-1:0]     xsize_r,     xsize_nxt;
  logic [NODE_W-1:0]   yroot_r,     yroot_nxt;
  logic [SZ_W-1:0]     ysize_r,     ysize_nxt;
  logic [NODE_W-1:0]   res_root_r,  res_root_nxt;
  logic [SZ_W-1:0]     res_size_r,  res_size_nxt;
  logic                res_same_r,  res_same_nxt;
  logic                res_merged_r, res_merged_nxt;

  // Decoded table entry
  logic                ent_root;
  logic [SZ_W-1:0]     ent_val;
  logic [NODE_W-1:0]   ent_next;

  // Request decode
  logic                req_bad;
  logic [NODE_W-1:0]   a_idx;
  logic [NODE_W-1:0]   b_idx;

  // Union decision
  logic                y_wins;
  logic [NODE_W-1:0]   winner;
  logic [NODE_W-1:0]   loser;
  logic [SZ_W-1:0]     size_sum;

  assign ent_root = mem_rdata[E_W-1];
  assign ent_val  = mem_rdata[SZ_W-1:0];
  assign ent_next = mem_rdata[NODE_W-1:0];

  assign a_idx   = NODE_W'(cmd.node_a);
  assign b_idx   = NODE_W'(cmd.node_b);
  assign req_bad = ({1'b0, cmd.node_a} >= n_used) ||
                   ((cmd.action != ACT_FIND) && ({1'b0, cmd.node_b} >= n_used));

  // Larger set wins, ties go to node_a's root
  assign y_wins   = (xsize_r < ysize_r);
  assign winner   = y_wins ? yroot_r : xroot_r;
  assign loser    = y_wins ? xroot_r : yroot_r;
  assign size_sum = xsize_r + ysize_r;

  assign cmd_ready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  assign res.root_node = NODE_FW'(res_root_r);
  assign res.set_size  = SIZE_FW'(res_size_r);
  assign res.same_set  = res_same_r;
  assign res.merged    = res_merged_r;
  assign res.set_count = sets_left_r;

  // Next-state and table access
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    sets_left_nxt  = sets_left_r;
    which_nxt      = which_r;
    act_nxt        = act_r;
    b_nxt          = b_r;
    cur_nxt        = cur_r;
    start_nxt      = start_r;
    root_nxt       = root_r;
    xroot_nxt      = xroot_r;
    xsize_nxt      = xsize_r;
    yroot_nxt      = yroot_r;
    ysize_nxt      = ysize_r;
    res_root_nxt   = res_root_r;
    res_size_nxt   = res_size_r;
    res_same_nxt   = res_same_r;
    res_merged_nxt = res_merged_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = {1'b0, SZ_W'(root_r)};
    mem_raddr      = cur_r;

    unique case (state_r)
      // Sweep every entry back to a singleton root
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = ENTRY_SINGLE;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a request; count and bad nodes answer at once
      S_IDLE: begin
        if (cmd_valid) begin
          act_nxt        = cmd.action;
          b_nxt          = b_idx;
          res_root_nxt   = '0;
          res_size_nxt   = '0;
          res_same_nxt   = 1'b0;
          res_merged_nxt = 1'b0;
          if ((cmd.action == ACT_COUNT) || req_bad) begin
            state_nxt = S_DONE;
          end else begin
            mem_raddr = a_idx;
            cur_nxt   = a_idx;
            start_nxt = a_idx;
            which_nxt = 1'b0;
            state_nxt = S_F1;
          end
        end
      end

      // First pass: follow parent links up to the root
      S_F1: begin
        if (ent_root) begin
          root_nxt = cur_r;
          if (!which_r) begin
            xroot_nxt = cur_r;
            xsize_nxt = ent_val;
          end else begin
            yroot_nxt = cur_r;
            ysize_nxt = ent_val;
          end
          if (cur_r == start_r) begin
            state_nxt = S_NEXT;
          end else begin
            mem_raddr = start_r;
            cur_nxt   = start_r;
            state_nxt = S_F2;
          end
        end else begin
          mem_raddr = ent_next;
          cur_nxt   = ent_next;
        end
      end

      // Second pass: point each node on the path at the root
      S_F2: begin
        mem_we    = !ent_root;
        mem_waddr = cur_r;
        mem_wdata = {1'b0, SZ_W'(root_r)};
        if (ent_root || (ent_next == root_r)) begin
          state_nxt = S_NEXT;
        end else begin
          mem_raddr = ent_next;
          cur_nxt   = ent_next;
        end
      end

      // Between finds: start the second one, answer, or merge
      S_NEXT: begin
        if (!which_r) begin
          if (act_r == ACT_FIND) begin
            res_root_nxt = xroot_r;
            res_size_nxt = xsize_r;
            state_nxt    = S_DONE;
          end else begin
            mem_raddr = b_r;
            cur_nxt   = b_r;
            start_nxt = b_r;
            which_nxt = 1'b1;
            state_nxt = S_F1;
          end
        end else if ((act_r == ACT_UNION) && (xroot_r != yroot_r)) begin
          // winner root takes the combined size
          mem_we    = 1'b1;
          mem_waddr = winner;
          mem_wdata = {1'b1, size_sum};
          state_nxt = S_MERGE;
        end else begin
          res_root_nxt = xroot_r;
          res_size_nxt = xsize_r;
          res_same_nxt = (xroot_r == yroot_r);
          state_nxt    = S_DONE;
        end
      end

      // Hang the losing root under the winner
      S_MERGE: begin
        mem_we         = 1'b1;
        mem_waddr      = loser;
        mem_wdata      = {1'b0, SZ_W'(winner)};
        if (sets_left_r != '0) begin
          sets_left_nxt = sets_left_r - 1'b1;
        end
        res_root_nxt   = winner;
        res_size_nxt   = size_sum;
        res_same_nxt   = 1'b1;
        res_merged_nxt = 1'b1;
        state_nxt      = S_DONE;
      end

      // Hold the answer until the output register takes it
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write restarts the sweep and the set count
    if (cfg_we) begin
      state_nxt     = S_CLEAR;
      clr_addr_nxt  = '0;
      sets_left_nxt = n_new;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      sets_left_r <= clamp_nodes(NUM_NODES_RST, NODES);
      which_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      sets_left_r <= sets_left_nxt;
      which_r     <= which_nxt;
    end
  end

  // Working values and answer
  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    b_r          <= b_nxt;
    cur_r        <= cur_nxt;
    start_r      <= start_nxt;
    root_r       <= root_nxt;
    xroot_r      <= xroot_nxt;
    xsize_r      <= xsize_nxt;
    yroot_r      <= yroot_nxt;
    ysize_r      <= ysize_nxt;
    res_root_r   <= res_root_nxt;
    res_size_r   <= res_size_nxt;
    res_same_r   <= res_same_nxt;
    res_merged_r <= res_merged_nxt;
  end

endmodule

[rtl/union_find_engine.sv]
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set engine: union by size, find with path compression, set count.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): one action per transfer with node_a
//   and node_b. Output channel (out_valid/out_ready): exactly one answer per
//   action, in order. cfg_we/cfg_wdata writes the node count; the write
//   clears the table and reloads the set count.
// Operation
//   Count and bad-node actions go straight to the answer, with no table access.
//   A find walks the parent links up to the root; unless the start node is
//   itself the root, a compression pass then points each node on the path
//   at the root (path length at most about log2 NODES). A find action runs
//   one find; union and query run two finds, and a merge adds one step.
//   The table's single read port with registered read data sets the pace;
//   one action is in work at a time.
// Reset and stalls
//   After reset and after each register write, a sweep sets every entry
//   to a singleton; in_ready stays low meanwhile. The answer sits in an
//   output register, so a new action is taken while it waits; a further
//   answer holds in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module union_find_engine
  import ufe_pkg::*;
#(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [SIZE_FW-1:0] cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [NODE_FW-1:0] in_node_a,
  input  logic [NODE_FW-1:0] in_node_b,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NODE_FW-1:0] out_root_node,
  output logic [SIZE_FW-1:0] out_set_size,
  output logic               out_same_set,
  output logic               out_merged,
  output logic [SIZE_FW-1:0] out_set_count
);

  localparam int unsigned NODE_W = $clog2(NODES);
  localparam int unsigned E_W    = NODE_W + 2;

  logic [SIZE_FW-1:0] num_nodes_r;
  logic [SIZE_FW-1:0] n_used;
  logic [SIZE_FW-1:0] n_new;

  cmd_t               cmd;
  result_t            res;
  logic               res_valid;
  logic               res_ready;

  logic               mem_we;
  logic [NODE_W-1:0]  mem_waddr;
  logic [E_W-1:0]     mem_wdata;
  logic [NODE_W-1:0]  mem_raddr;
  logic [E_W-1:0]     mem_rdata;

  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r;

  // Node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= NUM_NODES_RST;
    end else if (cfg_we) begin
      num_nodes_r <= cfg_wdata;
    end
  end

  assign n_used = clamp_nodes(num_nodes_r, NODES);
  assign n_new  = clamp_nodes(cfg_wdata, NODES);

  assign cmd.action = action_t'(in_action);
  assign cmd.node_a = in_node_a;
  assign cmd.node_b = in_node_b;

  ufe_seq #(
    .NODES (NODES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .n_new     (n_new),
    .n_used    (n_used),
    .cmd_valid (in_valid),
    .cmd_ready (in_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ufe_table #(
    .NODES (NODES)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads when empty or emptied by this cycle's transfer
  assign res_ready = res_valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root_node = out_res_r.root_node;
  assign out_set_size  = out_res_r.set_size;
  assign out_same_set  = out_res_r.same_set;
  assign out_merged    = out_res_r.merged;
  assign out_set_count = out_res_r.set_count;

endmodule
